// ===== rtl/cbrf_pkg.sv =====
// cbrf_pkg: shared widths, status codes, control word layout and the
// microprogram rom of the cubic bisection root finder.
// No dependencies; used by every module of the block.
package cbrf_pkg;

	localparam int IN_W      = 24;  // interval ends and root, signed fixed point
	localparam int FRAC_BITS = 16;
	localparam int MAX_ITER  = 64;
	localparam int TOL_W     = 17;
	localparam int LIM_W     = 7;
	localparam int ITER_W    = 7;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 17;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);
	localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(48);

	// register indexes on the config channel
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 1'b1;

	// datapath widths: x*x is nonnegative, so the square needs no sign bit
	localparam int SQ_W    = 2 * IN_W - 1 - FRAC_BITS;
	localparam int MUL_A_W = SQ_W + 1;
	localparam int PROD_W  = MUL_A_W + IN_W;
	localparam int P_W     = PROD_W - FRAC_BITS + 2;
	localparam int DIFF_W  = IN_W + 1;

	localparam logic [STAT_W-1:0] STATUS_CONVERGED = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_ZERO      = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_NO_CHANGE = 2'd2;
	localparam logic [STAT_W-1:0] STATUS_LIMIT     = 2'd3;

	localparam int STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD_L,
		OP_LOAD_R,
		OP_LOAD_C,
		OP_TAKE_SQ,
		OP_ACC,
		OP_SIGN_L,
		OP_SIGN_R,
		OP_SIGN_C,
		OP_HALVE,
		OP_FINISH
	} op_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_XX,
		MUL_SQX
	} mul_t;

	typedef enum logic [2:0] {
		JMP_NEXT,
		JMP_ALWAYS,
		JMP_WAIT,
		JMP_NARROW,
		JMP_LIMIT,
		JMP_ZERO,
		JMP_NO_CHANGE
	} jump_t;

	typedef struct packed {
		op_t                op;
		mul_t               mul;
		jump_t              jump;
		step_t              target;
		logic [STAT_W-1:0]  stat;
	} ctrl_t;

	// branch conditions reported by the datapath
	typedef struct packed {
		logic narrow;
		logic limit;
		logic zero;
		logic no_change;
	} cond_t;

	typedef struct packed {
		logic zero;
		logic neg;
	} sign_t;

	// program layout
	localparam step_t ST_IDLE    = 5'd0;
	localparam step_t ST_EVAL_L  = 5'd1;
	localparam step_t ST_EVAL_R  = 5'd6;
	localparam step_t ST_LOOP    = 5'd11;
	localparam step_t ST_LIMIT   = 5'd12;
	localparam step_t ST_EVAL_C  = 5'd13;
	localparam step_t ST_ZERO    = 5'd18;
	localparam step_t ST_CHANGE  = 5'd19;
	localparam step_t ST_HALVE   = 5'd20;
	localparam step_t ST_DONE_CV = 5'd21;
	localparam step_t ST_DONE_ZR = 5'd22;
	localparam step_t ST_DONE_NC = 5'd23;
	localparam step_t ST_DONE_LM = 5'd24;

	function automatic ctrl_t cw(op_t op, mul_t mul, jump_t jump, step_t target,
			logic [STAT_W-1:0] stat);
		ctrl_t w;
		w.op     = op;
		w.mul    = mul;
		w.jump   = jump;
		w.target = target;
		w.stat   = stat;
		return w;
	endfunction

	// one evaluation of p(x) takes five words: load x, x*x, square, sq*x, sign
	function automatic ctrl_t rom(step_t step);
		ctrl_t w;
		unique case (step)
			5'd0:  w = cw(OP_NOP,     MUL_NONE, JMP_WAIT,      ST_IDLE,    STATUS_CONVERGED);
			5'd1:  w = cw(OP_LOAD_L,  MUL_NONE, JMP_NEXT,      ST_IDLE,    STATUS_CONVERGED);
			5'd2:  w = cw(OP_NOP,     MUL_XX,   JMP_NEXT,      ST_IDLE,    STATUS_CONVERGED);
			5'd3:  w = cw(OP_TAKE_SQ, MUL_NONE, JMP_NEXT,      ST_IDLE,    STATUS_CONVERGED);
			5'd4:  w = cw(OP_ACC,     MUL_SQX,  JMP_NEXT,      ST_IDLE,    STATUS_CONVERGED);
			5'd5:  w = cw(OP_SIGN_L,  MUL_NONE, JMP_NEXT,      ST_IDLE,    STATUS_CONVERGED);
			5'd6:  w = cw(OP_LOAD_R,  MUL_NONE, JMP_NEXT,      ST_IDLE,    STATUS_CONVERGED);
			5'd7:  w = cw(OP_NOP,     MUL_XX,   JMP_NEXT,      ST_IDLE,    STATUS_CONVERGED);
			5'd8:  w = cw(OP_TAKE_SQ, MUL_NONE, JMP_NEXT,      ST_IDLE,    STATUS_CONVERGED);
			5'd9:  w = cw(OP_ACC,     MUL_SQX,  JMP_NEXT,      ST_IDLE,    STATUS_CONVERGED);
			5'd10: w = cw(OP_SIGN_R,  MUL_NONE, JMP_NEXT,      ST_IDLE,    STATUS_CONVERGED);
			5'd11: w = cw(OP_NOP,     MUL_NONE, JMP_NARROW,    ST_DONE_CV, STATUS_CONVERGED);
			5'd12: w = cw(OP_NOP,     MUL_NONE, JMP_LIMIT,     ST_DONE_LM, STATUS_CONVERGED);
			5'd13: w = cw(OP_LOAD_C,  MUL_NONE, JMP_NEXT,      ST_IDLE,    STATUS_CONVERGED);
			5'd14: w = cw(OP_NOP,     MUL_XX,   JMP_NEXT,      ST_IDLE,    STATUS_CONVERGED);
			5'd15: w = cw(OP_TAKE_SQ, MUL_NONE, JMP_NEXT,      ST_IDLE,    STATUS_CONVERGED);
			5'd16: w = cw(OP_ACC,     MUL_SQX,  JMP_NEXT,      ST_IDLE,    STATUS_CONVERGED);
			5'd17: w = cw(OP_SIGN_C,  MUL_NONE, JMP_NEXT,      ST_IDLE,    STATUS_CONVERGED);
			5'd18: w = cw(OP_NOP,     MUL_NONE, JMP_ZERO,      ST_DONE_ZR, STATUS_CONVERGED);
			5'd19: w = cw(OP_NOP,     MUL_NONE, JMP_NO_CHANGE, ST_DONE_NC, STATUS_CONVERGED);
			5'd20: w = cw(OP_HALVE,   MUL_NONE, JMP_ALWAYS,    ST_LOOP,    STATUS_CONVERGED);
			5'd21: w = cw(OP_FINISH,  MUL_NONE, JMP_ALWAYS,    ST_IDLE,    STATUS_CONVERGED);
			5'd22: w = cw(OP_FINISH,  MUL_NONE, JMP_ALWAYS,    ST_IDLE,    STATUS_ZERO);
			5'd23: w = cw(OP_FINISH,  MUL_NONE, JMP_ALWAYS,    ST_IDLE,    STATUS_NO_CHANGE);
			5'd24: w = cw(OP_FINISH,  MUL_NONE, JMP_ALWAYS,    ST_IDLE,    STATUS_LIMIT);
			default: w = cw(OP_NOP,   MUL_NONE, JMP_ALWAYS,    ST_IDLE,    STATUS_CONVERGED);
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/cubic_bisection_root_finder.sv =====
// Bisection root finder for the cubic -2x^3 - x^2 + 5x + 1 in signed Q8.16.
// Holds the tolerance and iteration limit registers; instantiates
// cbrf_sequencer and cbrf_datapath, both built on cbrf_pkg.
//
// Usage:
//   start/busy: an interval (left_end, right_end) is taken at a clock edge
//   with start high and busy low. busy stays high while the search runs.
//   done: high for exactly one cycle with root, iterations and status valid;
//   the receiver must take it then, there is no back-pressure.
//   cfg_valid/cfg_ready: register writes (index 0 tolerance, 1 iteration
//   limit); cfg_ready is always high, write only while no search runs.
// Sequence: a microprogram of 25 words drives one shared 32x24 multiplier;
//   each p(x) evaluation loads x, forms x*x, takes the square, forms sq*x
//   and takes the sign. Setup evaluates both ends and each halving
//   evaluates the midpoint; the search ends when the interval is narrow,
//   the limit is reached, the midpoint is an exact zero or there is no
//   sign change. The next start is taken in the cycle done is high.
// Reset: arst_n clears the sequencer and done, and loads tolerance 66 and
//   limit 48. No result is produced out of reset.
module cubic_bisection_root_finder (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [cbrf_pkg::IN_W-1:0]       left_end,
	input  logic signed [cbrf_pkg::IN_W-1:0]       right_end,
	output logic                                   done,
	output logic signed [cbrf_pkg::IN_W-1:0]       root,
	output logic        [cbrf_pkg::ITER_W-1:0]     iterations,
	output logic        [cbrf_pkg::STAT_W-1:0]     status,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic        [cbrf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [cbrf_pkg::CFG_DAT_W-1:0]  cfg_data
);

	logic [cbrf_pkg::TOL_W-1:0] tol_q;
	logic [cbrf_pkg::LIM_W-1:0] lim_q;
	logic                       accept;
	cbrf_pkg::ctrl_t            ctrl;
	cbrf_pkg::cond_t            cond;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= cbrf_pkg::TOL_RESET;
			lim_q <= cbrf_pkg::LIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cbrf_pkg::REG_TOLERANCE:  tol_q <= cfg_data[cbrf_pkg::TOL_W-1:0];
				cbrf_pkg::REG_ITER_LIMIT: lim_q <= cfg_data[cbrf_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	cbrf_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cond   (cond),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	cbrf_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.left_end        (left_end),
		.right_end       (right_end),
		.tolerance       (tol_q),
		.iteration_limit (lim_q),
		.ctrl            (ctrl),
		.cond            (cond),
		.done            (done),
		.root            (root),
		.iterations      (iterations),
		.status          (status)
	);

endmodule

// ===== rtl/cbrf_sequencer.sv =====
// cbrf_sequencer: step counter, microprogram rom lookup and jump logic.
// Depends on cbrf_pkg for the control word, conditions and program layout.
module cbrf_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  cbrf_pkg::cond_t      cond,
	output cbrf_pkg::ctrl_t      ctrl,
	output logic                 busy
);

	cbrf_pkg::step_t step_q;
	cbrf_pkg::step_t step_next;
	logic            take;

	assign ctrl = cbrf_pkg::rom(step_q);
	assign busy = (step_q != cbrf_pkg::ST_IDLE);

	always_comb begin
		unique case (ctrl.jump)
			cbrf_pkg::JMP_NEXT:      take = 1'b0;
			cbrf_pkg::JMP_ALWAYS:    take = 1'b1;
			cbrf_pkg::JMP_WAIT:      take = !start;
			cbrf_pkg::JMP_NARROW:    take = cond.narrow;
			cbrf_pkg::JMP_LIMIT:     take = cond.limit;
			cbrf_pkg::JMP_ZERO:      take = cond.zero;
			cbrf_pkg::JMP_NO_CHANGE: take = cond.no_change;
			default:                 take = 1'b1;
		endcase
		// wait holds on its own step, other jumps use the target field
		if (take) begin
			step_next = (ctrl.jump == cbrf_pkg::JMP_WAIT) ? step_q : ctrl.target;
		end else begin
			step_next = step_q + cbrf_pkg::STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= cbrf_pkg::ST_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

// ===== rtl/cbrf_datapath.sv =====
// cbrf_datapath: interval registers, shared multiplier, polynomial sign
// evaluation, bisection update and result registers.
// Depends on cbrf_pkg; driven by the control word of cbrf_sequencer.
module cbrf_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic signed [cbrf_pkg::IN_W-1:0]      left_end,
	input  logic signed [cbrf_pkg::IN_W-1:0]      right_end,
	input  logic        [cbrf_pkg::TOL_W-1:0]     tolerance,
	input  logic        [cbrf_pkg::LIM_W-1:0]     iteration_limit,
	input  cbrf_pkg::ctrl_t                       ctrl,
	output cbrf_pkg::cond_t                       cond,
	output logic                                  done,
	output logic signed [cbrf_pkg::IN_W-1:0]      root,
	output logic        [cbrf_pkg::ITER_W-1:0]    iterations,
	output logic        [cbrf_pkg::STAT_W-1:0]    status
);

	localparam int IN_W    = cbrf_pkg::IN_W;
	localparam int SQ_W    = cbrf_pkg::SQ_W;
	localparam int MUL_A_W = cbrf_pkg::MUL_A_W;
	localparam int PROD_W  = cbrf_pkg::PROD_W;
	localparam int P_W     = cbrf_pkg::P_W;
	localparam int DIFF_W  = cbrf_pkg::DIFF_W;
	localparam int TOL_W   = cbrf_pkg::TOL_W;
	localparam int LIM_W   = cbrf_pkg::LIM_W;
	localparam int ITER_W  = cbrf_pkg::ITER_W;
	localparam int FRAC    = cbrf_pkg::FRAC_BITS;

	logic signed [IN_W-1:0]   l_q, r_q, c_q, x_q;
	logic        [SQ_W-1:0]   sq_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [P_W-1:0]    acc_q;
	cbrf_pkg::sign_t          sl_q, sr_q, sc_q;
	logic        [ITER_W-1:0] k_q;
	logic        [LIM_W-1:0]  lim_q;
	logic                     done_q;
	logic signed [IN_W-1:0]   root_q;
	logic        [ITER_W-1:0] iter_q;
	logic [cbrf_pkg::STAT_W-1:0] status_q;

	logic signed [DIFF_W-1:0]  sum, diff, tol2, tol2_neg;
	logic signed [IN_W-1:0]    mid;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [PROD_W-1:0]  product;
	logic signed [PROD_W-1:0]  prod_shr;
	logic signed [P_W-1:0]     x_ext, acc_next, cu2, p_val;
	cbrf_pkg::sign_t           p_sign;
	logic                      sl_flips, sr_flips;
	logic        [LIM_W-1:0]   lim_clamped;

	// floor midpoint without overflow
	assign sum = {l_q[IN_W-1], l_q} + {r_q[IN_W-1], r_q};
	assign mid = sum[DIFF_W-1:1];

	assign diff     = {r_q[IN_W-1], r_q} - {l_q[IN_W-1], l_q};
	assign tol2     = {{(DIFF_W-TOL_W-1){1'b0}}, tolerance, 1'b0};
	assign tol2_neg = -tol2;

	assign sl_flips = !sl_q.zero && (sl_q.neg != sc_q.neg);
	assign sr_flips = !sr_q.zero && (sr_q.neg != sc_q.neg);

	assign cond.narrow    = (diff <= tol2) && (diff >= tol2_neg);
	assign cond.limit     = (k_q >= lim_q);
	assign cond.zero      = sc_q.zero;
	assign cond.no_change = !sl_flips && !sr_flips;

	// shared multiplier: x*x, then square*x
	assign mul_a   = (ctrl.mul == cbrf_pkg::MUL_SQX) ? $signed({1'b0, sq_q})
		: $signed({{(MUL_A_W-IN_W){x_q[IN_W-1]}}, x_q});
	assign product = mul_a * x_q;

	assign prod_shr = prod_q >>> FRAC;

	// 5x + 1.0 - sq, then subtract 2*cube in the sign step
	assign x_ext    = {{(P_W-IN_W){x_q[IN_W-1]}}, x_q};
	assign acc_next = (x_ext <<< 2) + x_ext + (P_W'(1) <<< FRAC)
		- $signed({{(P_W-SQ_W){1'b0}}, sq_q});
	assign cu2      = {prod_shr[P_W-2:0], 1'b0};
	assign p_val    = acc_q - cu2;
	assign p_sign.zero = (p_val == '0);
	assign p_sign.neg  = p_val[P_W-1];

	assign lim_clamped = (iteration_limit > LIM_W'(cbrf_pkg::MAX_ITER))
		? LIM_W'(cbrf_pkg::MAX_ITER) : iteration_limit;

	always_ff @(posedge clk) begin
		if (accept) begin
			l_q   <= left_end;
			r_q   <= right_end;
			k_q   <= '0;
			lim_q <= lim_clamped;
		end
		if (ctrl.mul != cbrf_pkg::MUL_NONE) begin
			prod_q <= product;
		end
		unique case (ctrl.op)
			cbrf_pkg::OP_NOP:     ;
			cbrf_pkg::OP_LOAD_L:  x_q <= l_q;
			cbrf_pkg::OP_LOAD_R:  x_q <= r_q;
			cbrf_pkg::OP_LOAD_C: begin
				x_q <= mid;
				c_q <= mid;
			end
			cbrf_pkg::OP_TAKE_SQ: sq_q  <= prod_shr[SQ_W-1:0];
			cbrf_pkg::OP_ACC:     acc_q <= acc_next;
			cbrf_pkg::OP_SIGN_L:  sl_q  <= p_sign;
			cbrf_pkg::OP_SIGN_R:  sr_q  <= p_sign;
			cbrf_pkg::OP_SIGN_C:  sc_q  <= p_sign;
			cbrf_pkg::OP_HALVE: begin
				// keep the half whose end differs in sign from the midpoint
				if (sl_flips) begin
					r_q  <= c_q;
					sr_q <= sc_q;
				end else begin
					l_q  <= c_q;
					sl_q <= sc_q;
				end
				k_q <= k_q + ITER_W'(1);
			end
			cbrf_pkg::OP_FINISH: begin
				root_q   <= mid;
				iter_q   <= k_q;
				status_q <= ctrl.stat;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (ctrl.op == cbrf_pkg::OP_FINISH);
		end
	end

	assign done       = done_q;
	assign root       = root_q;
	assign iterations = iter_q;
	assign status     = status_q;

endmodule

// ===== tb/tb_cubic_bisection_root_finder.sv =====
`timescale 1ns / 1ps

// tb_cubic_bisection_root_finder: self-checking testbench for the cubic bisection root finder.
// Predicts every search in a scoreboard class and compares each done pulse against it.
// Depends on cbrf_pkg and cubic_bisection_root_finder.
module tb_cubic_bisection_root_finder;
	import cbrf_pkg::*;

	localparam int     WATCHDOG_LIMIT  = 4000;
	localparam int     PHASES          = 12;
	localparam int     ITEMS_PER_PHASE = 75;
	localparam longint END_MAX         = 4194304;
	localparam longint ROOT_NEAR[3]    = '{-115300, -12800, 95355};
	localparam longint TOL_SET[8]      = '{0, 1, 65536, 131071, 66, 200, 0, 7};
	localparam longint LIM_SET[8]      = '{64, 127, 0, 1, 48, 10, 0, 3};

	typedef struct {
		logic signed [IN_W-1:0] root;
		logic [ITER_W-1:0]      iterations;
		logic [STAT_W-1:0]      status;
	} search_result_t;

	class bisection_checker;
		logic [TOL_W-1:0] tolerance;
		logic [LIM_W-1:0] iter_limit;
		search_result_t   expected_roots[$];
		int               errors;

		function new();
			tolerance  = TOL_RESET;
			iter_limit = LIM_RESET;
			errors     = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) begin
				$display("%s", msg);
			end
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
			if (index == REG_TOLERANCE) begin
				tolerance = data[TOL_W-1:0];
			end else begin
				iter_limit = data[LIM_W-1:0];
			end
		endfunction

		// fixed-point cubic, each product floored back to the fraction width
		function longint cubic_value(longint x);
			longint sq, cu;
			sq = (x * x) >>> FRAC_BITS;
			cu = (sq * x) >>> FRAC_BITS;
			return -2 * cu - sq + 5 * x + (longint'(1) << FRAC_BITS);
		endfunction

		function int cubic_sign(longint x);
			longint v;
			v = cubic_value(x);
			return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
		endfunction

		function search_result_t bisect(logic signed [IN_W-1:0] left, logic signed [IN_W-1:0] right);
			search_result_t res;
			longint l, r, c, width, twice_tol;
			int lim, k, sl, sc, sr;
			l         = longint'(left);
			r         = longint'(right);
			twice_tol = 2 * longint'(tolerance);
			lim       = (iter_limit > MAX_ITER) ? MAX_ITER : int'(iter_limit);
			k         = 0;
			res.status = STATUS_CONVERGED;
			forever begin
				width = (r > l) ? r - l : l - r;
				if (width <= twice_tol) begin
					res.status = STATUS_CONVERGED;
					break;
				end
				if (k >= lim) begin
					res.status = STATUS_LIMIT;
					break;
				end
				c  = (l + r) >>> 1;
				sc = cubic_sign(c);
				if (sc == 0) begin
					res.status = STATUS_ZERO;
					break;
				end
				sl = cubic_sign(l);
				sr = cubic_sign(r);
				if (sl != 0 && sl != sc) begin
					r = c;
				end else if (sr != 0 && sr != sc) begin
					l = c;
				end else begin
					res.status = STATUS_NO_CHANGE;
					break;
				end
				k++;
			end
			res.root       = IN_W'((l + r) >>> 1);
			res.iterations = ITER_W'(k);
			return res;
		endfunction

		function void note_interval(logic signed [IN_W-1:0] left, logic signed [IN_W-1:0] right);
			expected_roots.push_back(bisect(left, right));
		endfunction

		function void check_result(logic signed [IN_W-1:0] root, logic [ITER_W-1:0] iterations,
				logic [STAT_W-1:0] status);
			search_result_t want;
			if (expected_roots.size() == 0) begin
				flag($sformatf("unexpected result: root %0d iterations %0d status %0d",
					root, iterations, status));
			end else begin
				want = expected_roots.pop_front();
				if (want.root !== root || want.iterations !== iterations
						|| want.status !== status) begin
					flag($sformatf({"result mismatch: root exp %0d got %0d, ",
						"iterations exp %0d got %0d, status exp %0d got %0d"},
						want.root, root, want.iterations, iterations, want.status, status));
				end
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic signed [IN_W-1:0]  left_end;
	logic signed [IN_W-1:0]  right_end;
	logic                    done;
	logic signed [IN_W-1:0]  root;
	logic [ITER_W-1:0]       iterations;
	logic [STAT_W-1:0]       status;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DAT_W-1:0]    cfg_data;

	bisection_checker bisect_check;
	longint           found_zeros[$];
	int               idle_cycles;

	cubic_bisection_root_finder dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// monitor: notes interval transfers, checks done pulses, watches for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				bisect_check.note_interval(left_end, right_end);
			end
			if (done) begin
				bisect_check.check_result(root, iterations, status);
			end
			if ((start && !busy) || done) begin
				idle_cycles = 0;
			end else begin
				idle_cycles = idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	function automatic longint signed_rand(longint mag);
		return longint'($urandom_range(0, 32'(2 * mag))) - mag;
	endfunction

	function automatic int sender_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			return 0;
		end else if (pick < 90) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(10, 150);
	endfunction

	function automatic void pick_interval(output logic signed [IN_W-1:0] l,
			output logic signed [IN_W-1:0] r);
		int kind;
		longint a, b, centre, half, z;
		kind = $urandom_range(0, 99);
		if (kind >= 75 && kind < 85 && found_zeros.size() == 0) begin
			kind = 0;
		end
		if (kind < 30) begin
			a = signed_rand(END_MAX);
			b = signed_rand(END_MAX);
		end else if (kind < 55) begin
			// bracket one of the three real roots, widths spread over many octaves
			centre = ROOT_NEAR[$urandom_range(0, 2)] + signed_rand(4096);
			half   = $urandom_range(1, 1 << $urandom_range(4, 22));
			a      = centre - half;
			b      = centre + half;
			if ($urandom_range(0, 1)) begin
				a = centre + half;
				b = centre - half;
			end
		end else if (kind < 65) begin
			a = longint'($urandom());
			b = longint'($urandom());
		end else if (kind < 75) begin
			a = signed_rand(END_MAX);
			b = a + signed_rand(2 * longint'(bisect_check.tolerance) + 2);
		end else if (kind < 85) begin
			z    = found_zeros[$urandom_range(0, found_zeros.size() - 1)];
			half = $urandom_range(1, 100000);
			case ($urandom_range(0, 2))
				0: begin
					a = z - half;
					b = z + half;
				end
				1: begin
					a = z;
					b = z + half;
				end
				default: begin
					a = z - half;
					b = z;
				end
			endcase
		end else begin
			a = signed_rand(END_MAX);
			b = a + signed_rand(longint'(1) << $urandom_range(0, 12));
		end
		l = IN_W'(a);
		r = IN_W'(b);
	endfunction

	// start stays high after the transfer so back-to-back items need no second assignment
	task automatic send_interval(input logic signed [IN_W-1:0] l, input logic signed [IN_W-1:0] r);
		start     <= 1'b1;
		left_end  <= l;
		right_end <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic hold_sender(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (bisect_check.expected_roots.size() != 0 || busy) begin
			@(posedge clk);
		end
		repeat (2) @(posedge clk);
	endtask

	task automatic write_settings(input longint tol, input longint lim);
		cfg_valid <= 1'b1;
		cfg_index <= REG_TOLERANCE;
		cfg_data  <= CFG_DAT_W'(tol);
		do @(posedge clk); while (!cfg_ready);
		bisect_check.set_register(REG_TOLERANCE, CFG_DAT_W'(tol));
		cfg_index <= REG_ITER_LIMIT;
		cfg_data  <= CFG_DAT_W'(lim);
		do @(posedge clk); while (!cfg_ready);
		bisect_check.set_register(REG_ITER_LIMIT, CFG_DAT_W'(lim));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		longint                 dir_left[$], dir_right[$];
		longint                 tol, lim;
		logic signed [IN_W-1:0] l, r;
		bit                     no_idle;

		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		left_end     = '0;
		right_end    = '0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_TOLERANCE;
		cfg_data     = '0;
		idle_cycles  = 0;
		bisect_check = new();

		// look for points where the fixed-point cubic is exactly zero near each root
		foreach (ROOT_NEAR[i]) begin
			for (longint x = ROOT_NEAR[i] - 10000; x <= ROOT_NEAR[i] + 10000; x++) begin
				if (found_zeros.size() < 8 && bisect_check.cubic_value(x) == 0) begin
					found_zeros.push_back(x);
				end
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed intervals at reset settings
		dir_left  = '{-END_MAX, END_MAX, -8388608, 8388607, 0, 0, 0, 65536, 131072,
			-65536, -131072, 0, -262144, -END_MAX, END_MAX, -1, 8388607};
		dir_right = '{END_MAX, -END_MAX, 8388607, -8388608, 0, 132, 133, 131072, 65536,
			0, -65536, 65536, -196608, -END_MAX, END_MAX, 0, 8388607};
		for (int i = 0; i < found_zeros.size() && i < 2; i++) begin
			dir_left.push_back(found_zeros[i] - 4096);
			dir_right.push_back(found_zeros[i] + 4096);
			dir_left.push_back(found_zeros[i]);
			dir_right.push_back(found_zeros[i] + 50000);
			dir_left.push_back(found_zeros[i] - 50000);
			dir_right.push_back(found_zeros[i]);
		end
		foreach (dir_left[i]) begin
			hold_sender($urandom_range(0, 1) ? 0 : $urandom_range(1, 20));
			send_interval(IN_W'(dir_left[i]), IN_W'(dir_right[i]));
		end

		// random phases, each with its own register settings written while idle
		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			if (phase < 8) begin
				tol = TOL_SET[phase];
				lim = LIM_SET[phase];
			end else begin
				tol = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
					: $urandom_range(0, 600);
				lim = $urandom_range(0, 127);
			end
			write_settings(tol, lim);
			no_idle = (phase == 1) || ($urandom_range(0, 4) == 0);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick_interval(l, r);
				if (!no_idle) begin
					hold_sender(sender_gap());
				end
				send_interval(l, r);
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (bisect_check.expected_roots.size() != 0) begin
			bisect_check.flag($sformatf("%0d results never arrived",
				bisect_check.expected_roots.size()));
		end
		if (bisect_check.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
